// ===== rtl/damped_follow_with_bounds_clamp_macros.svh =====
// ----------------------------------------------------------------------------
// Damped follow assertion macros
// Shared concurrent assertion forms for the camera follow block.
// ----------------------------------------------------------------------------
`ifndef DAMPED_FOLLOW_WITH_BOUNDS_CLAMP_MACROS_SVH
`define DAMPED_FOLLOW_WITH_BOUNDS_CLAMP_MACROS_SVH

// same-cycle implication
`define DFBC_AST_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DFBC_AST_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/dfbc_pkg.sv =====
// ----------------------------------------------------------------------------
// Damped follow package
// Shared constants, register indices, request type and saturation helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package dfbc_pkg;

  localparam int FRAC_BITS_DEF   = 16;
  localparam int PERSPECTIVE_DEF = 1;
  localparam int DT_BITS         = 16;
  localparam int OP_W            = 64;

  localparam logic [3:0] REG_PAN_OMEGA    = 4'd0;
  localparam logic [3:0] REG_HEIGHT_OMEGA = 4'd1;
  localparam logic [3:0] REG_BOUND_MIN_X  = 4'd2;
  localparam logic [3:0] REG_BOUND_MIN_Z  = 4'd3;
  localparam logic [3:0] REG_BOUND_MAX_X  = 4'd4;
  localparam logic [3:0] REG_BOUND_MAX_Z  = 4'd5;
  localparam logic [3:0] REG_VIEW_SCALE_X = 4'd6;
  localparam logic [3:0] REG_VIEW_SCALE_Z = 4'd7;

  typedef struct packed {
    logic start;
    logic neg;
    logic sh_dt;
  } mul_req_t;

  function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
    logic signed [63:0] lo;
    logic signed [63:0] hi;
    lo = -(64'sd1 <<< 47);
    hi = (64'sd1 <<< 47) - 64'sd1;
    if (v < lo) return lo[47:0];
    if (v > hi) return hi[47:0];
    return v[47:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] lo;
    logic signed [63:0] hi;
    lo = -(64'sd1 <<< 31);
    hi = (64'sd1 <<< 31) - 64'sd1;
    if (v < lo) return lo[31:0];
    if (v > hi) return hi[31:0];
    return v[31:0];
  endfunction

  function automatic logic [OP_W-1:0] mag48(input logic signed [47:0] v);
    logic signed [48:0] w;
    w = {v[47], v};
    if (v[47]) w = -w;
    return {{(OP_W-49){1'b0}}, w};
  endfunction

endpackage

// ===== rtl/dfbc_mul.sv =====
// ----------------------------------------------------------------------------
// Damped follow shared multiplier
// Digit-serial magnitude multiply with 2^62 cap, shift and signed 48-bit form.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module dfbc_mul #(
  parameter int FRAC_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  dfbc_pkg::mul_req_t      req,
  input  logic [63:0]             a,
  input  logic [63:0]             b,
  output logic                    busy,
  output logic                    done,
  output logic [62:0]             res_u,
  output logic signed [47:0]      res_s
);
  import dfbc_pkg::*;

  logic [63:0]  aq;
  logic [63:0]  bq;
  logic [127:0] acc;
  logic [2:0]   cnt;
  logic         neg_q;
  logic         dt_q;

  logic [15:0]  digit;
  logic [79:0]  part;
  logic [127:0] part_sh;
  logic [62:0]  capped;
  logic [62:0]  shifted;
  logic [47:0]  pm;
  logic [47:0]  sres;

  assign digit   = bq[{cnt[1:0], 4'b0} +: 16];
  assign part    = aq * digit;
  assign part_sh = {48'b0, part} << {cnt[1:0], 4'b0};
  assign capped  = (acc > (128'd1 << 62)) ? (63'd1 << 62) : acc[62:0];
  assign shifted = dt_q ? (capped >> DT_BITS) : (capped >> FRAC_BITS);

  always_comb begin
    pm = (shifted > (63'd1 << 47)) ? (48'd1 << 47) : shifted[47:0];
    if (neg_q) begin
      sres = -pm;
    end else if (pm[47]) begin
      sres = (48'd1 << 47) - 48'd1;
    end else begin
      sres = pm;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 3'd0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        cnt   <= 3'd0;
        acc   <= '0;
        aq    <= a;
        bq    <= b;
        neg_q <= req.neg;
        dt_q  <= req.sh_dt;
      end else if (busy) begin
        if (cnt == 3'd4) begin
          busy  <= 1'b0;
          done  <= 1'b1;
          res_u <= shifted;
          res_s <= $signed(sres);
        end else begin
          acc <= acc + part_sh;
          cnt <= cnt + 3'd1;
        end
      end
    end
  end

endmodule

// ===== rtl/dfbc_div.sv =====
// ----------------------------------------------------------------------------
// Damped follow divider
// Restoring bit-serial division of 2^(2F) by the decay denominator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module dfbc_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] den,
  output logic        done,
  output logic [63:0] quo
);
  import dfbc_pkg::*;

  localparam int ITER  = 2 * FRAC_BITS + 1;
  localparam int CNT_W = $clog2(ITER + 1);

  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [63:0]      rem;
  logic [63:0]      den_q;
  logic [64:0]      trial;
  logic [64:0]      diff;
  logic             ge;

  assign trial = {rem, (cnt == '0)};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        rem   <= '0;
        quo   <= '0;
        den_q <= den;
      end else if (busy) begin
        rem <= ge ? diff[63:0] : trial[63:0];
        quo <= {quo[62:0], ge};
        if (cnt == CNT_W'(ITER - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + CNT_W'(1);
        end
      end
    end
  end

endmodule

// ===== rtl/damped_follow_with_bounds_clamp.sv =====
// ----------------------------------------------------------------------------
// Damped follow with bounds clamp
// Critically damped camera follow on three axes with pan clamped to track.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel item_valid/item_stall carries step_time and three aims; a
//   transaction is taken when item_valid is high and item_stall is low.
//   Result channel result_valid/result_stall carries place_x/height/z.
//   Register writes (wr_en, wr_index, wr_data) must be made by the user only
//   while the block is idle; the block itself does not enforce this. Each
//   tick runs on one shared digit-serial multiplier and one bit-serial
//   divider: two decay factors of five products and one divide each, five
//   products per axis, two half-view products with perspective view.
//   item_stall stays high from transaction to result, so the next tick is
//   taken only after the previous one has reached its result step.
//   Reset clears positions and velocities and loads the register defaults.
//   A stalled result holds; the next tick may be taken meanwhile and waits
//   at its final step until the output register frees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module damped_follow_with_bounds_clamp #(
  parameter int FRAC_BITS        = dfbc_pkg::FRAC_BITS_DEF,
  parameter int PERSPECTIVE_VIEW = dfbc_pkg::PERSPECTIVE_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic [15:0]        step_time,
  input  logic signed [31:0] aim_x,
  input  logic signed [31:0] aim_z,
  input  logic signed [31:0] aim_height,
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [31:0] place_x,
  output logic signed [31:0] place_height,
  output logic signed [31:0] place_z,
  input  logic               wr_en,
  input  logic [3:0]         wr_index,
  input  logic [31:0]        wr_data
);
  import dfbc_pkg::*;

  localparam logic [63:0] ONE_F = 64'd1 << FRAC_BITS;
  localparam logic [63:0] C048  = ((64'd48 << FRAC_BITS) + 64'd50) / 64'd100;
  localparam logic [63:0] C235  = ((64'd235 << FRAC_BITS) + 64'd500) / 64'd1000;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DX    = 4'd1;
  localparam logic [3:0] S_DX2   = 4'd2;
  localparam logic [3:0] S_DX3   = 4'd3;
  localparam logic [3:0] S_D48   = 4'd4;
  localparam logic [3:0] S_D235  = 4'd5;
  localparam logic [3:0] S_DDIV  = 4'd6;
  localparam logic [3:0] S_ACHG  = 4'd7;
  localparam logic [3:0] S_ATMP  = 4'd8;
  localparam logic [3:0] S_ANV   = 4'd9;
  localparam logic [3:0] S_AVEL  = 4'd10;
  localparam logic [3:0] S_APOS  = 4'd11;
  localparam logic [3:0] S_HX    = 4'd12;
  localparam logic [3:0] S_HZ    = 4'd13;
  localparam logic [3:0] S_CLAMP = 4'd14;

  logic [23:0]        pan_omega;
  logic [23:0]        height_omega;
  logic signed [31:0] bound_min_x;
  logic signed [31:0] bound_min_z;
  logic signed [31:0] bound_max_x;
  logic signed [31:0] bound_max_z;
  logic [23:0]        view_scale_x;
  logic [23:0]        view_scale_z;

  logic signed [31:0] pos [0:2];
  logic signed [31:0] vel [0:2];
  logic signed [31:0] aim [0:2];
  logic [15:0]        dt;

  logic [3:0]         state;
  logic               wt;
  logic               grp;
  logic [1:0]         ax;
  logic [62:0]        x1;
  logic [62:0]        x2;
  logic [62:0]        x3;
  logic [63:0]        den;
  logic [63:0]        e_fac [0:1];
  logic signed [47:0] chg;
  logic signed [47:0] t1;
  logic signed [47:0] tmp;
  logic signed [47:0] nv;
  logic signed [47:0] hx;
  logic signed [47:0] hz;

  mul_req_t           mreq;
  logic [63:0]        ma;
  logic [63:0]        mb;
  logic               mbusy;
  logic               mdone;
  logic [62:0]        mres_u;
  logic signed [47:0] mres_s;
  logic               dstart;
  logic               ddone;
  logic [63:0]        dquo;

  logic               accept;
  logic               mul_state;
  logic signed [47:0] chg_now;
  logic signed [47:0] ct;
  logic [63:0]        omega_a;
  logic [63:0]        e_a;
  logic signed [47:0] half_x;
  logic signed [47:0] half_z;
  logic signed [31:0] clamp_x;
  logic signed [31:0] clamp_z;

  function automatic logic signed [31:0] bclamp(input logic signed [31:0] p,
                                                input logic signed [31:0] lo_b,
                                                input logic signed [31:0] hi_b,
                                                input logic signed [47:0] half);
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic signed [31:0] r;
    lo = sat32(64'(lo_b) + 64'(half));
    hi = sat32(64'(hi_b) - 64'(half));
    r = p;
    if (r < lo) r = lo;
    if (r > hi) r = hi;
    return r;
  endfunction

  assign accept     = item_valid && !item_stall;
  assign item_stall = (state != S_IDLE);
  assign mul_state  = (state inside {S_DX, S_DX2, S_DX3, S_D48, S_D235, S_ACHG, S_ATMP,
                                     S_ANV, S_AVEL, S_APOS, S_HX, S_HZ});
  assign chg_now    = sat48(64'(pos[ax]) - 64'(aim[ax]));
  assign ct         = sat48(64'(chg) + 64'(tmp));
  assign omega_a    = {40'b0, (ax == 2'd2) ? height_omega : pan_omega};
  assign e_a        = (ax == 2'd2) ? e_fac[1] : e_fac[0];
  assign half_x     = (PERSPECTIVE_VIEW != 0) ? hx : 48'(view_scale_x);
  assign half_z     = (PERSPECTIVE_VIEW != 0) ? hz : 48'(view_scale_z);
  assign clamp_x    = bclamp(pos[0], bound_min_x, bound_max_x, half_x);
  assign clamp_z    = bclamp(pos[1], bound_min_z, bound_max_z, half_z);
  assign dstart     = (state == S_D235) && wt && mdone;

  always_comb begin
    mreq.start = mul_state && !wt;
    mreq.neg   = 1'b0;
    mreq.sh_dt = 1'b0;
    ma         = '0;
    mb         = '0;
    case (state)
      S_DX: begin
        ma         = {40'b0, grp ? height_omega : pan_omega};
        mb         = {48'b0, dt};
        mreq.sh_dt = 1'b1;
      end
      S_DX2: begin
        ma = {1'b0, x1};
        mb = {1'b0, x1};
      end
      S_DX3: begin
        ma = {1'b0, x2};
        mb = {1'b0, x1};
      end
      S_D48: begin
        ma = C048;
        mb = {1'b0, x2};
      end
      S_D235: begin
        ma = C235;
        mb = {1'b0, x3};
      end
      S_ACHG: begin
        ma       = mag48(chg_now);
        mb       = omega_a;
        mreq.neg = chg_now[47];
      end
      S_ATMP: begin
        ma         = mag48(t1);
        mb         = {48'b0, dt};
        mreq.neg   = t1[47];
        mreq.sh_dt = 1'b1;
      end
      S_ANV: begin
        ma       = mag48(tmp);
        mb       = omega_a;
        mreq.neg = tmp[47];
      end
      S_AVEL: begin
        ma       = mag48(nv);
        mb       = e_a;
        mreq.neg = nv[47];
      end
      S_APOS: begin
        ma       = mag48(ct);
        mb       = e_a;
        mreq.neg = ct[47];
      end
      S_HX: begin
        ma       = mag48(48'(pos[2]));
        mb       = {40'b0, view_scale_x};
        mreq.neg = pos[2][31];
      end
      S_HZ: begin
        ma       = mag48(48'(pos[2]));
        mb       = {40'b0, view_scale_z};
        mreq.neg = pos[2][31];
      end
      default: begin
        ma = '0;
      end
    endcase
  end

  dfbc_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .req   (mreq),
    .a     (ma),
    .b     (mb),
    .busy  (mbusy),
    .done  (mdone),
    .res_u (mres_u),
    .res_s (mres_s)
  );

  dfbc_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (dstart),
    .den   (den + {1'b0, mres_u}),
    .done  (ddone),
    .quo   (dquo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pan_omega    <= 24'd262144;
      height_omega <= 24'd262144;
      bound_min_x  <= -32'sd6553600;
      bound_min_z  <= -32'sd6553600;
      bound_max_x  <= 32'sd6553600;
      bound_max_z  <= 32'sd6553600;
      view_scale_x <= 24'd65536;
      view_scale_z <= 24'd65536;
    end else if (wr_en) begin
      case (wr_index)
        REG_PAN_OMEGA:    pan_omega    <= wr_data[23:0];
        REG_HEIGHT_OMEGA: height_omega <= wr_data[23:0];
        REG_BOUND_MIN_X:  bound_min_x  <= $signed(wr_data);
        REG_BOUND_MIN_Z:  bound_min_z  <= $signed(wr_data);
        REG_BOUND_MAX_X:  bound_max_x  <= $signed(wr_data);
        REG_BOUND_MAX_Z:  bound_max_z  <= $signed(wr_data);
        REG_VIEW_SCALE_X: view_scale_x <= wr_data[23:0];
        REG_VIEW_SCALE_Z: view_scale_z <= wr_data[23:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      wt           <= 1'b0;
      grp          <= 1'b0;
      ax           <= 2'd0;
      result_valid <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        pos[i] <= '0;
        vel[i] <= '0;
      end
    end else begin
      if (result_valid && !result_stall && state != S_CLAMP) begin
        result_valid <= 1'b0;
      end
      if (mreq.start) begin
        wt <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            dt     <= step_time;
            aim[0] <= aim_x;
            aim[1] <= aim_z;
            aim[2] <= aim_height;
            grp    <= 1'b0;
            state  <= S_DX;
          end
        end
        S_DX: begin
          if (wt && mdone) begin
            x1    <= mres_u;
            wt    <= 1'b0;
            state <= S_DX2;
          end
        end
        S_DX2: begin
          if (wt && mdone) begin
            x2    <= mres_u;
            wt    <= 1'b0;
            state <= S_DX3;
          end
        end
        S_DX3: begin
          if (wt && mdone) begin
            x3    <= mres_u;
            wt    <= 1'b0;
            state <= S_D48;
          end
        end
        S_D48: begin
          if (wt && mdone) begin
            den   <= ONE_F + {1'b0, x1} + {1'b0, mres_u};
            wt    <= 1'b0;
            state <= S_D235;
          end
        end
        S_D235: begin
          if (wt && mdone) begin
            wt    <= 1'b0;
            state <= S_DDIV;
          end
        end
        S_DDIV: begin
          if (ddone) begin
            e_fac[grp] <= dquo;
            if (!grp) begin
              grp   <= 1'b1;
              state <= S_DX;
            end else begin
              ax    <= 2'd0;
              state <= S_ACHG;
            end
          end
        end
        S_ACHG: begin
          if (wt && mdone) begin
            chg   <= chg_now;
            t1    <= sat48(64'(vel[ax]) + 64'(mres_s));
            wt    <= 1'b0;
            state <= S_ATMP;
          end
        end
        S_ATMP: begin
          if (wt && mdone) begin
            tmp   <= mres_s;
            wt    <= 1'b0;
            state <= S_ANV;
          end
        end
        S_ANV: begin
          if (wt && mdone) begin
            nv    <= sat48(64'(vel[ax]) - 64'(mres_s));
            wt    <= 1'b0;
            state <= S_AVEL;
          end
        end
        S_AVEL: begin
          if (wt && mdone) begin
            vel[ax] <= sat32(64'(mres_s));
            wt      <= 1'b0;
            state   <= S_APOS;
          end
        end
        S_APOS: begin
          if (wt && mdone) begin
            pos[ax] <= sat32(64'(aim[ax]) + 64'(mres_s));
            wt      <= 1'b0;
            if (ax != 2'd2) begin
              ax    <= ax + 2'd1;
              state <= S_ACHG;
            end else if (PERSPECTIVE_VIEW != 0) begin
              state <= S_HX;
            end else begin
              state <= S_CLAMP;
            end
          end
        end
        S_HX: begin
          if (wt && mdone) begin
            hx    <= mres_s;
            wt    <= 1'b0;
            state <= S_HZ;
          end
        end
        S_HZ: begin
          if (wt && mdone) begin
            hz    <= mres_s;
            wt    <= 1'b0;
            state <= S_CLAMP;
          end
        end
        S_CLAMP: begin
          if (!result_valid || !result_stall) begin
            pos[0]       <= clamp_x;
            pos[1]       <= clamp_z;
            place_x      <= clamp_x;
            place_z      <= clamp_z;
            place_height <= pos[2];
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `include "damped_follow_with_bounds_clamp_macros.svh"

  `DFBC_AST_NOW(a_mul_free, mreq.start, !mbusy, "multiplier restarted while busy")
  `DFBC_AST_NOW(a_div_owner, ddone, state == S_DDIV, "divider result outside divide step")
  `DFBC_AST_NEXT(a_accept_start, accept, state == S_DX && !wt, "transaction did not start decay")

endmodule
